[rtl/bit_frame_synchronizer_macros.svh]
// Assertion helpers for the frame synchroniser.
`ifndef BIT_FRAME_SYNCHRONIZER_MACROS_SVH
`define BIT_FRAME_SYNCHRONIZER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/bfs_pkg.sv]
package bfs_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 16;
   localparam int ROT_W       = 2;
   localparam int COUNT_W     = 8;
   localparam int OUTQ_DEPTH  = 2;
   localparam int OUTQ_PTR_W  = 1;

   localparam logic MOD_BPSK = 1'b0;
   localparam logic MOD_QPSK = 1'b1;

   localparam logic [7:0]  PREAMBLE_BYTE_RST  = 8'd170;
   localparam logic [4:0]  PREAMBLE_BYTES_RST = 5'd8;
   localparam logic [3:0]  SYNC_BYTES_RST     = 4'd4;
   localparam logic [15:0] MAX_FRAME_RST      = 16'd6144;

   // 1/10 as a fixed-point reciprocal, exact for windows up to 64 bits
   localparam logic [15:0] TENTH_MUL   = 16'd205;
   localparam int          TENTH_SHIFT = 11;

   typedef enum logic [2:0] {
      CSR_MODULATION      = 3'd0,
      CSR_PREAMBLE_BYTE   = 3'd1,
      CSR_PREAMBLE_BYTES  = 3'd2,
      CSR_SYNC_PATTERN    = 3'd3,
      CSR_SYNC_BYTES      = 3'd4,
      CSR_MAX_FRAME_BYTES = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_PREAMBLE = 2'd0,
      PH_SYNC     = 2'd1,
      PH_LENGTH   = 2'd2,
      PH_PAYLOAD  = 2'd3
   } sync_phase_type;

   typedef enum logic [1:0] {
      ROT_NONE = 2'd0,
      ROT_90   = 2'd1,
      ROT_180  = 2'd2,
      ROT_270  = 2'd3
   } rot_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

   typedef struct packed {
      logic       pre_bit;
      logic       pre_en;
      logic       sync_en;
      logic [3:0] sync_bit;   // indexed by rotation code
   } cell_pat_type;

   typedef struct packed {
      logic       pre;
      logic [3:0] sync;
   } cell_miss_type;

   typedef struct packed {
      logic pre;
      logic straight;
      logic inverted;
      logic rot90;
      logic rot180;
      logic rot270;
   } sync_hit_type;

   typedef struct packed {
      logic                 modulation;
      logic [LEN_W-1:0]     max_frame_bytes;
      logic [COUNT_W-1:0]   timeout_limit;
   } ctrl_cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic              frame_last;
      logic [ROT_W-1:0]  phase_found;
   } result_type;

endpackage

[rtl/bfs_if.sv]
interface bfs_req_if import bfs_pkg::*; ();
   logic valid;
   logic ready;
   logic rx_bit;

   modport source (output valid, output rx_bit, input ready);
   modport sink (input valid, input rx_bit, output ready);
endinterface

interface bfs_rsp_if import bfs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] payload_byte;
   logic              frame_last;
   logic [ROT_W-1:0]  phase_found;

   modport source (output valid, output payload_byte, output frame_last,
                   output phase_found, input ready);
   modport sink (input valid, input payload_byte, input frame_last,
                 input phase_found, output ready);
endinterface

interface bfs_csr_if import bfs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/bfs_cell.sv]
module bfs_cell import bfs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          shift_in,
   input  cell_ctl_type  ctl,
   input  cell_pat_type  pat,
   output logic          q,
   output cell_miss_type miss
);

   logic value_ff;
   logic value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.clear) begin
         value_in = 1'b0;
      end else if (ctl.shift) begin
         value_in = shift_in;
      end
   end

   // compared against the history as it stands after this shift
   always_comb begin
      miss.pre = (shift_in ^ pat.pre_bit) & pat.pre_en;
      for (int r = 0; r < 4; r++) begin
         miss.sync[r] = (shift_in ^ pat.sync_bit[r]) & pat.sync_en;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= 1'b0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign q = value_ff;

endmodule

[rtl/bfs_chain.sv]
module bfs_chain import bfs_pkg::*; #(
   parameter int HIST_BITS = 64,
   parameter int CW        = $clog2(HIST_BITS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_bit,
   input  cell_ctl_type          ctl,
   input  logic [BYTE_W-1:0]     preamble_byte,
   input  logic [CSR_DATA_W-1:0] sync_pattern,
   input  logic [CW-1:0]         win_len,
   input  logic [CW-1:0]         sync_len,
   input  logic [CW-1:0]         pre_thr,
   input  logic [CW-1:0]         sync_thr,
   output sync_hit_type          hits
);

   localparam int GROUPS = (HIST_BITS + 7) / 8;
   localparam int PAD    = GROUPS * 8;

   logic          q    [HIST_BITS];
   cell_pat_type  pat  [HIST_BITS];
   cell_miss_type miss [HIST_BITS];

   logic [HIST_BITS-1:0] pre_vec;
   logic [HIST_BITS-1:0] sync_vec [4];
   logic [CW-1:0]        pre_cnt;
   logic [CW-1:0]        sync_cnt [4];

   function automatic logic [CW-1:0] ones(input logic [HIST_BITS-1:0] v);
      logic [PAD-1:0] pv;
      logic [3:0]     part;
      logic [CW-1:0]  total;
      pv    = PAD'(v);
      total = '0;
      for (int g = 0; g < GROUPS; g++) begin
         part = '0;
         for (int b = 0; b < 8; b++) begin
            part = part + 4'(pv[g*8 + b]);
         end
         total = total + CW'(part);
      end
      return total;
   endfunction

   for (genvar i = 0; i < HIST_BITS; i++) begin : g_cell
      logic shift_in;

      if (i == 0) begin : g_head
         assign shift_in = in_bit;
      end else begin : g_link
         assign shift_in = q[i-1];
      end

      assign pat[i].pre_bit     = preamble_byte[i % 8];
      assign pat[i].pre_en      = win_len > CW'(i);
      assign pat[i].sync_en     = sync_len > CW'(i);
      assign pat[i].sync_bit[0] = sync_pattern[i];

      if (i % 2 == 0) begin : g_low
         assign pat[i].sync_bit[1] = ~sync_pattern[i];
         assign pat[i].sync_bit[2] = sync_pattern[i];
         assign pat[i].sync_bit[3] = ~sync_pattern[i];
      end else begin : g_high
         assign pat[i].sync_bit[1] = sync_pattern[i] ^ sync_pattern[i-1];
         assign pat[i].sync_bit[2] = ~sync_pattern[i];
         assign pat[i].sync_bit[3] = ~(sync_pattern[i] ^ sync_pattern[i-1]);
      end

      bfs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_in (shift_in),
         .ctl      (ctl),
         .pat      (pat[i]),
         .q        (q[i]),
         .miss     (miss[i])
      );
   end

   always_comb begin
      for (int i = 0; i < HIST_BITS; i++) begin
         pre_vec[i] = miss[i].pre;
         for (int r = 0; r < 4; r++) begin
            sync_vec[r][i] = miss[i].sync[r];
         end
      end
   end

   always_comb begin
      pre_cnt = ones(pre_vec);
      for (int r = 0; r < 4; r++) begin
         sync_cnt[r] = ones(sync_vec[r]);
      end
   end

   always_comb begin
      hits.pre      = pre_cnt <= pre_thr;
      hits.straight = sync_cnt[0] <= sync_thr;
      hits.inverted = sync_cnt[0] >= (sync_len - sync_thr);
      hits.rot90    = sync_cnt[1] <= sync_thr;
      hits.rot180   = sync_cnt[2] <= sync_thr;
      hits.rot270   = sync_cnt[3] <= sync_thr;
   end

endmodule

[rtl/bfs_ctrl.sv]
module bfs_ctrl import bfs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic           rx_bit,
   input  sync_hit_type   hits,
   input  ctrl_cfg_type   cfg,
   output cell_ctl_type   cell_ctl,
   output logic           res_valid,
   output result_type     result,
   output sync_phase_type phase
);

   sync_phase_type     phase_ff, phase_in;
   logic [COUNT_W-1:0] search_cnt_ff, search_cnt_in;
   logic [2:0]         bits_ff, bits_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic [LEN_W-1:0]   done_ff, done_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   rot_type            rot_ff, rot_in;
   logic               held_bit_ff, held_bit_in;
   logic               held_valid_ff, held_valid_in;

   logic               go_length;
   rot_type            go_rot;
   logic               timeout;
   logic [COUNT_W-1:0] cnt_inc;
   logic [1:0]         add;
   logic [BYTE_W-1:0]  asm;
   logic [3:0]         total;
   logic               byte_done;
   logic [LEN_W-1:0]   len_new;
   logic [LEN_W-1:0]   done_inc;
   logic               len_bad;
   logic               is_last;
   logic               h, l;

   always_comb begin : decode
      go_length = 1'b1;
      go_rot    = ROT_NONE;
      timeout   = 1'b0;
      cnt_inc   = (search_cnt_ff == '1) ? search_cnt_ff : search_cnt_ff + COUNT_W'(1);
      if (hits.straight) begin
         go_rot = ROT_NONE;
      end else if (cfg.modulation == MOD_BPSK && hits.inverted) begin
         go_rot = ROT_90;
      end else if (cfg.modulation == MOD_QPSK && hits.rot90) begin
         go_rot = ROT_90;
      end else if (cfg.modulation == MOD_QPSK && hits.rot180) begin
         go_rot = ROT_180;
      end else if (cfg.modulation == MOD_QPSK && hits.rot270) begin
         go_rot = ROT_270;
      end else begin
         go_length = 1'b0;
         timeout   = cnt_inc > cfg.timeout_limit;
      end

      case (rot_ff)
         ROT_90: begin
            h = ~(held_bit_ff ^ rx_bit);
            l = ~rx_bit;
         end
         ROT_180: begin
            h = ~held_bit_ff;
            l = rx_bit;
         end
         ROT_270: begin
            h = held_bit_ff ^ rx_bit;
            l = ~rx_bit;
         end
         default: begin
            h = held_bit_ff;
            l = rx_bit;
         end
      endcase

      add = 2'd0;
      asm = byte_ff;
      if (cfg.modulation == MOD_BPSK) begin
         asm = {byte_ff[BYTE_W-2:0], rx_bit ^ (rot_ff != ROT_NONE)};
         add = 2'd1;
      end else if (held_valid_ff) begin
         asm = {byte_ff[BYTE_W-3:0], h, l};
         add = 2'd2;
      end
      total     = 4'(bits_ff) + 4'(add);
      byte_done = (add != 2'd0) && (total >= 4'd8);
      len_new   = {len_ff[BYTE_W-1:0], asm};
      done_inc  = done_ff + LEN_W'(1);
      len_bad   = (len_new == '0) || (len_new > cfg.max_frame_bytes);
      is_last   = done_inc == len_ff;
   end

   always_comb begin : next_state
      logic clear_frame;
      clear_frame   = 1'b0;
      phase_in      = phase_ff;
      search_cnt_in = search_cnt_ff;
      bits_in       = bits_ff;
      byte_in       = byte_ff;
      done_in       = done_ff;
      len_in        = len_ff;
      rot_in        = rot_ff;
      held_bit_in   = held_bit_ff;
      held_valid_in = held_valid_ff;

      if (accept) begin
         case (phase_ff)
            PH_PREAMBLE: begin
               if (hits.pre) begin
                  phase_in      = PH_SYNC;
                  search_cnt_in = '0;
               end
            end
            PH_SYNC: begin
               search_cnt_in = cnt_inc;
               if (go_length) begin
                  phase_in    = PH_LENGTH;
                  rot_in      = go_rot;
                  clear_frame = 1'b1;
               end else if (timeout) begin
                  phase_in    = PH_PREAMBLE;
                  clear_frame = 1'b1;
               end
            end
            default: begin
               if (cfg.modulation == MOD_BPSK) begin
                  byte_in       = asm;
                  held_valid_in = 1'b0;
               end else if (!held_valid_ff) begin
                  held_bit_in   = rx_bit;
                  held_valid_in = 1'b1;
               end else begin
                  byte_in       = asm;
                  held_valid_in = 1'b0;
               end
               if (add != 2'd0) begin
                  if (!byte_done) begin
                     bits_in = total[2:0];
                  end else begin
                     bits_in = '0;
                     byte_in = '0;
                     if (phase_ff == PH_LENGTH) begin
                        len_in  = len_new;
                        done_in = done_inc;
                        if (done_inc >= LEN_W'(2)) begin
                           if (len_bad) begin
                              phase_in    = PH_PREAMBLE;
                              clear_frame = 1'b1;
                           end else begin
                              phase_in = PH_PAYLOAD;
                              done_in  = '0;
                           end
                        end
                     end else begin
                        done_in = done_inc;
                        if (is_last) begin
                           phase_in    = PH_PREAMBLE;
                           clear_frame = 1'b1;
                        end
                     end
                  end
               end
            end
         endcase
      end

      if (clear_frame) begin
         search_cnt_in = '0;
         bits_in       = '0;
         byte_in       = '0;
         done_in       = '0;
         len_in        = '0;
         held_valid_in = 1'b0;
      end
   end

   always_comb begin : outputs
      cell_ctl.shift = accept && (phase_ff == PH_PREAMBLE || phase_ff == PH_SYNC);
      cell_ctl.clear = accept && ((phase_ff == PH_PREAMBLE && hits.pre) ||
                                  (phase_ff == PH_SYNC && (go_length || timeout)));
      res_valid           = accept && (phase_ff == PH_PAYLOAD) && byte_done;
      result.payload_byte = asm;
      result.frame_last   = is_last;
      result.phase_found  = rot_ff;
      phase               = phase_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_PREAMBLE;
         search_cnt_ff <= '0;
         bits_ff       <= '0;
         byte_ff       <= '0;
         done_ff       <= '0;
         len_ff        <= '0;
         rot_ff        <= ROT_NONE;
         held_bit_ff   <= 1'b0;
         held_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         search_cnt_ff <= search_cnt_in;
         bits_ff       <= bits_in;
         byte_ff       <= byte_in;
         done_ff       <= done_in;
         len_ff        <= len_in;
         rot_ff        <= rot_in;
         held_bit_ff   <= held_bit_in;
         held_valid_ff <= held_valid_in;
      end
   end

endmodule

[rtl/bfs_outq.sv]
module bfs_outq import bfs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       pop_valid,
   input  logic       pop_ready,
   output result_type pop_data
);

   localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

   result_type            entry_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUTQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  pop;

   assign full      = count_ff == CNT_W'(OUTQ_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + OUTQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + OUTQ_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/bit_frame_synchronizer.sv]
// Frame synchroniser for a stream of hard-decision bits.
// req_bus carries one received bit per word. The block hunts for the
// repeated preamble byte, then the sync word (straight, BPSK-inverted or
// QPSK-rotated), reads a 16-bit big-endian length and then hands out the
// payload on rsp_bus one byte per word, MSB first, phase undone, with
// frame_last on the closing byte and the detected rotation in phase_found.
// Bad lengths (zero or above max_frame_bytes) drop the frame silently.
// csr_bus writes the six registers by index; it is always ready and should
// only be used while no frame is in flight.
// Throughput: one bit per cycle while the result queue is not full. The
// history lives in a row of shift cells whose mismatch flags feed parallel
// popcounts, so each bit is judged in the cycle it is taken. A payload byte
// is written into the result queue when the word carrying its last bit is
// taken. Results go through a two-word queue; req_bus.ready drops only
// while both words are held, even if the receiver takes one that cycle.
// Reset (synchronous) returns to preamble search with empty history and
// restores the register defaults; no clearing pass is needed.
module bit_frame_synchronizer import bfs_pkg::*; #(
   parameter int MAX_SYNC_BYTES  = 8,
   parameter int MAX_WINDOW_BITS = 64
) (
   input logic      clock,
   input logic      reset,
   bfs_req_if.sink  req_bus,
   bfs_rsp_if.source rsp_bus,
   bfs_csr_if.sink  csr_bus
);

`include "bit_frame_synchronizer_macros.svh"

   localparam int SYNC_BITS = 8 * MAX_SYNC_BYTES;
   localparam int HIST_BITS = (MAX_WINDOW_BITS > SYNC_BITS) ? MAX_WINDOW_BITS : SYNC_BITS;
   localparam int CW        = $clog2(HIST_BITS + 1);

   logic                  modulation_ff;
   logic [7:0]            preamble_byte_ff;
   logic [4:0]            preamble_bytes_ff;
   logic [CSR_DATA_W-1:0] sync_pattern_ff;
   logic [3:0]            sync_bytes_ff;
   logic [LEN_W-1:0]      max_frame_ff;

   logic [4:0]     pb_eff;
   logic [3:0]     sb_eff;
   logic [CW-1:0]  win_len, sync_len, pre_thr, sync_thr;
   ctrl_cfg_type   cfg;
   logic           accept;
   logic           q_full;
   cell_ctl_type   cell_ctl;
   sync_hit_type   hits;
   logic           res_valid;
   result_type     result;
   result_type     rsp_data;
   sync_phase_type phase;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulation_ff     <= MOD_BPSK;
         preamble_byte_ff  <= PREAMBLE_BYTE_RST;
         preamble_bytes_ff <= PREAMBLE_BYTES_RST;
         sync_pattern_ff   <= '0;
         sync_bytes_ff     <= SYNC_BYTES_RST;
         max_frame_ff      <= MAX_FRAME_RST;
      end else if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_MODULATION:      modulation_ff     <= csr_bus.data[0];
            CSR_PREAMBLE_BYTE:   preamble_byte_ff  <= csr_bus.data[7:0];
            CSR_PREAMBLE_BYTES:  preamble_bytes_ff <= csr_bus.data[4:0];
            CSR_SYNC_PATTERN:    sync_pattern_ff   <= csr_bus.data;
            CSR_SYNC_BYTES:      sync_bytes_ff     <= csr_bus.data[3:0];
            CSR_MAX_FRAME_BYTES: max_frame_ff      <= csr_bus.data[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      pb_eff = preamble_bytes_ff;
      if (preamble_bytes_ff < 5'd2) begin
         pb_eff = 5'd2;
      end else if (preamble_bytes_ff > 5'(MAX_WINDOW_BITS / 4)) begin
         pb_eff = 5'(MAX_WINDOW_BITS / 4);
      end
      sb_eff = sync_bytes_ff;
      if (sync_bytes_ff < 4'd1) begin
         sb_eff = 4'd1;
      end else if (sync_bytes_ff > 4'(MAX_SYNC_BYTES)) begin
         sb_eff = 4'(MAX_SYNC_BYTES);
      end
      win_len  = CW'({pb_eff, 2'b00});
      sync_len = CW'({sb_eff, 3'b000});
      sync_thr = CW'(sb_eff);
      pre_thr  = CW'((16'(win_len) * TENTH_MUL) >> TENTH_SHIFT);
      cfg.modulation      = modulation_ff;
      cfg.max_frame_bytes = max_frame_ff;
      cfg.timeout_limit   = COUNT_W'({5'(pb_eff) + 5'(sb_eff), 3'b000});
   end

   assign req_bus.ready = !q_full;
   assign accept        = req_bus.valid && req_bus.ready;

   bfs_chain #(
      .HIST_BITS (HIST_BITS),
      .CW        (CW)
   ) u_chain (
      .clock         (clock),
      .reset         (reset),
      .in_bit        (req_bus.rx_bit),
      .ctl           (cell_ctl),
      .preamble_byte (preamble_byte_ff),
      .sync_pattern  (sync_pattern_ff),
      .win_len       (win_len),
      .sync_len      (sync_len),
      .pre_thr       (pre_thr),
      .sync_thr      (sync_thr),
      .hits          (hits)
   );

   bfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_bit    (req_bus.rx_bit),
      .hits      (hits),
      .cfg       (cfg),
      .cell_ctl  (cell_ctl),
      .res_valid (res_valid),
      .result    (result),
      .phase     (phase)
   );

   bfs_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (result),
      .full      (q_full),
      .pop_valid (rsp_bus.valid),
      .pop_ready (rsp_bus.ready),
      .pop_data  (rsp_data)
   );

   assign rsp_bus.payload_byte = rsp_data.payload_byte;
   assign rsp_bus.frame_last   = rsp_data.frame_last;
   assign rsp_bus.phase_found  = rsp_data.phase_found;

   `BFS_ASSERT_NOW(a_result_needs_word, clock, reset, res_valid, accept,
      "result produced without an accepted word")
   `BFS_ASSERT_NOW(a_result_in_payload, clock, reset, res_valid, phase == PH_PAYLOAD,
      "result produced outside payload phase")
   `BFS_ASSERT_NEXT(a_last_ends_frame, clock, reset, res_valid && result.frame_last,
      phase == PH_PREAMBLE, "last byte did not return to preamble search")
   `BFS_ASSERT_NOW(a_stall_only_when_full, clock, reset, !req_bus.ready,
      rsp_bus.valid && !rsp_bus.ready || rsp_bus.valid,
      "input stalled with no result pending")

endmodule

[tb/sv/bit_frame_synchronizer_tb.sv]
module bit_frame_synchronizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bfs_pkg::*;

   logic clock;
   logic reset;

   bfs_req_if req_bus();
   bfs_rsp_if rsp_bus();
   bfs_csr_if csr_bus();

   bit_frame_synchronizer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   result_type expected_bytes[$];
   int         mismatches = 0;
   int         bytes_checked = 0;
   int         bits_sent = 0;
   bit         steady = 1'b0;
   bit         stall_start = 1'b0;

   // register copy
   logic        cfg_mod;
   logic [7:0]  cfg_pre_byte;
   logic [4:0]  cfg_pre_bytes;
   logic [63:0] cfg_sync;
   logic [3:0]  cfg_sync_bytes;
   logic [15:0] cfg_max_len;

   // receiver state
   sync_phase_type phase;
   logic [63:0]    history;
   logic [7:0]     search_cnt;
   int             nbits;
   logic [7:0]     assembly;
   logic [15:0]    done_cnt;
   logic [15:0]    rx_length;
   rot_type        rot_code;
   logic           held_bit;
   logic           held_valid;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] low_bits(int n);
      return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
   endfunction

   function automatic int window_bytes();
      int p;
      p = int'(cfg_pre_bytes);
      if (p < 2) p = 2;
      if (p > 16) p = 16;
      return p;
   endfunction

   function automatic int sync_len_bytes();
      int s;
      s = int'(cfg_sync_bytes);
      if (s < 1) s = 1;
      if (s > 8) s = 8;
      return s;
   endfunction

   // dibit (h, l) as seen after a carrier rotation, h in the odd position
   function automatic logic [63:0] rotate_pattern(logic [63:0] p, int n, rot_type r);
      logic [63:0] q;
      logic        h, l;
      int          k;
      q = '0;
      for (k = 0; k + 1 < n; k += 2) begin
         h = p[k+1];
         l = p[k];
         case (r)
            ROT_90: begin
               q[k+1] = h ^ l;
               q[k]   = ~l;
            end
            ROT_180: begin
               q[k+1] = ~h;
               q[k]   = l;
            end
            default: begin
               q[k+1] = ~(h ^ l);
               q[k]   = ~l;
            end
         endcase
      end
      return q;
   endfunction

   task automatic restart_search();
      phase      = PH_PREAMBLE;
      history    = '0;
      search_cnt = '0;
      nbits      = 0;
      assembly   = '0;
      done_cnt   = '0;
      rx_length  = '0;
      held_valid = 1'b0;
   endtask

   task automatic start_length(rot_type r);
      restart_search();
      phase    = PH_LENGTH;
      rot_code = r;
   endtask

   task automatic recover_bit(logic b);
      int          pb, sb, w, n, d, add;
      logic [63:0] pat, m, s;
      logic        h, l;
      logic [7:0]  rx_byte;
      result_type  r;
      pb = window_bytes();
      sb = sync_len_bytes();
      if (phase == PH_PREAMBLE) begin
         w = pb * 4;
         pat = '0;
         for (int i = 0; i < w; i++) pat[i] = cfg_pre_byte[i % 8];
         history = {history[62:0], b};
         if ($countones((history ^ pat) & low_bits(w)) <= w / 10) begin
            phase      = PH_SYNC;
            history    = '0;
            search_cnt = '0;
         end
      end else if (phase == PH_SYNC) begin
         n = sb * 8;
         m = low_bits(n);
         s = cfg_sync & m;
         history = {history[62:0], b};
         if (search_cnt < 8'd255) search_cnt++;
         d = $countones((history ^ s) & m);
         if (d <= sb) begin
            start_length(ROT_NONE);
         end else if (cfg_mod == MOD_BPSK && d >= n - sb) begin
            start_length(ROT_90);
         end else if (cfg_mod == MOD_QPSK &&
                      $countones((history ^ rotate_pattern(s, n, ROT_90)) & m) <= sb) begin
            start_length(ROT_90);
         end else if (cfg_mod == MOD_QPSK &&
                      $countones((history ^ rotate_pattern(s, n, ROT_180)) & m) <= sb) begin
            start_length(ROT_180);
         end else if (cfg_mod == MOD_QPSK &&
                      $countones((history ^ rotate_pattern(s, n, ROT_270)) & m) <= sb) begin
            start_length(ROT_270);
         end else if (search_cnt > (pb + sb) * 8) begin
            restart_search();
         end
      end else begin
         add = 0;
         if (cfg_mod == MOD_BPSK) begin
            assembly   = {assembly[6:0], b ^ (rot_code != ROT_NONE)};
            held_valid = 1'b0;
            add = 1;
         end else if (!held_valid) begin
            held_bit   = b;
            held_valid = 1'b1;
         end else begin
            case (rot_code)
               ROT_90: begin
                  h = ~(held_bit ^ b);
                  l = ~b;
               end
               ROT_180: begin
                  h = ~held_bit;
                  l = b;
               end
               ROT_270: begin
                  h = held_bit ^ b;
                  l = ~b;
               end
               default: begin
                  h = held_bit;
                  l = b;
               end
            endcase
            assembly   = {assembly[5:0], h, l};
            held_valid = 1'b0;
            add = 2;
         end
         if (add != 0) begin
            if (nbits + add < 8) begin
               nbits += add;
            end else begin
               nbits    = 0;
               rx_byte  = assembly;
               assembly = '0;
               if (phase == PH_LENGTH) begin
                  rx_length = {rx_length[7:0], rx_byte};
                  done_cnt++;
                  if (done_cnt >= 2) begin
                     if (rx_length == 0 || rx_length > cfg_max_len) begin
                        restart_search();
                     end else begin
                        phase    = PH_PAYLOAD;
                        done_cnt = '0;
                     end
                  end
               end else begin
                  done_cnt++;
                  r.payload_byte = rx_byte;
                  r.frame_last   = (done_cnt == rx_length);
                  r.phase_found  = rot_code;
                  expected_bytes.insert(expected_bytes.size(), r);
                  if (r.frame_last) restart_search();
               end
            end
         end
      end
   endtask

   task automatic report_error(string what);
      if (mismatches < 10) $display("ERROR: %s", what);
      mismatches++;
   endtask

   task automatic send_bit(logic b);
      while (!steady && $urandom_range(99) < 24) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.rx_bit <= b;
      do @(posedge clock); while (!req_bus.ready);
      bits_sent++;
      recover_bit(b);
   endtask

   task automatic send_noise(int n);
      repeat (n) send_bit(1'($urandom_range(1)));
   endtask

   function automatic logic [63:0] encode_field(logic [63:0] v, int n, rot_type r);
      if (r == ROT_NONE) return v;
      if (cfg_mod == MOD_BPSK) return ~v;
      return rotate_pattern(v, n, r);
   endfunction

   // preamble, sync word, length and nbytes payload bytes as the transmitter
   // would send them through a channel with rotation r
   task automatic send_frame(int len_field, int nbytes, rot_type r, int pre_errs,
                             int sync_errs);
      logic        tx_bits[$];
      logic [63:0] v;
      int          n, i, pos;
      n = sync_len_bytes() * 8;
      for (i = 0; i < window_bytes() * 8; i++)
         tx_bits.insert(tx_bits.size(), cfg_pre_byte[7 - i % 8]);
      repeat (pre_errs) begin
         pos = $urandom_range(tx_bits.size() - 1);
         tx_bits[pos] = ~tx_bits[pos];
      end
      v = encode_field(cfg_sync & low_bits(n), n, r);
      repeat (sync_errs) begin
         pos = $urandom_range(n - 1);
         v[pos] = ~v[pos];
      end
      for (i = n - 1; i >= 0; i--) tx_bits.insert(tx_bits.size(), v[i]);
      v = encode_field(64'(len_field), 16, r);
      for (i = 15; i >= 0; i--) tx_bits.insert(tx_bits.size(), v[i]);
      repeat (nbytes) begin
         v = encode_field(64'($urandom_range(255)), 8, r);
         for (i = 7; i >= 0; i--) tx_bits.insert(tx_bits.size(), v[i]);
      end
      foreach (tx_bits[j]) send_bit(tx_bits[j]);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [63:0] v);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= v;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_MODULATION:      cfg_mod        = v[0];
         CSR_PREAMBLE_BYTE:   cfg_pre_byte   = v[7:0];
         CSR_PREAMBLE_BYTES:  cfg_pre_bytes  = v[4:0];
         CSR_SYNC_PATTERN:    cfg_sync       = v;
         CSR_SYNC_BYTES:      cfg_sync_bytes = v[3:0];
         CSR_MAX_FRAME_BYTES: cfg_max_len    = v[15:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic mod, logic [7:0] pbyte, logic [4:0] pbytes,
                            logic [63:0] sync, logic [3:0] sbytes, logic [15:0] max_len,
                            bit noisy);
      logic [63:0] junk;
      junk = noisy ? {$urandom(), $urandom()} : '0;
      wait_drained();
      write_reg(CSR_MODULATION,      {junk[63:1], mod});
      write_reg(CSR_PREAMBLE_BYTE,   {junk[63:8], pbyte});
      write_reg(CSR_PREAMBLE_BYTES,  {junk[63:5], pbytes});
      write_reg(CSR_SYNC_PATTERN,    sync);
      write_reg(CSR_SYNC_BYTES,      {junk[63:4], sbytes});
      write_reg(CSR_MAX_FRAME_BYTES, {junk[63:16], max_len});
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // zero sync word against an empty history locks straight away
   task automatic test_reset_defaults();
      send_frame(3, 3, ROT_NONE, 0, 0);
      send_noise(20);
   endtask

   task automatic test_bpsk_phases();
      configure(MOD_BPSK, 8'h55, 5'd2, 64'hD391_7E2C_5B06_E4A1, 4'd2, 16'd16, 1'b0);
      send_frame(2, 2, ROT_NONE, 0, 0);
      send_frame(1, 1, ROT_90, 0, 2);
      send_frame(2, 2, ROT_NONE, 0, 1);
   endtask

   task automatic test_qpsk_rotations();
      configure(MOD_QPSK, 8'h33, 5'd2, 64'h0123_4567_89AB_C72D, 4'd2, 16'd16, 1'b0);
      send_frame(2, 2, ROT_NONE, 0, 0);
      send_frame(2, 2, ROT_90, 0, 1);
      send_frame(1, 1, ROT_180, 0, 0);
      send_frame(2, 2, ROT_270, 0, 2);
   endtask

   task automatic test_bad_lengths();
      configure(MOD_BPSK, 8'hA5, 5'd2, 64'h5A5A_5A5A_5A5A_9E1B, 4'd2, 16'd5, 1'b0);
      send_frame(0, 0, ROT_NONE, 0, 0);
      send_frame(6, 0, ROT_NONE, 0, 0);
      send_frame(16'hFFFF, 0, ROT_90, 0, 0);
      send_frame(5, 5, ROT_NONE, 0, 0);
      configure(MOD_BPSK, 8'hA5, 5'd2, 64'h5A5A_5A5A_5A5A_9E1B, 4'd2, 16'd0, 1'b0);
      send_frame(1, 0, ROT_NONE, 0, 0);
      configure(MOD_QPSK, 8'hA5, 5'd2, 64'h5A5A_5A5A_5A5A_9E1B, 4'd2, 16'hFFFF, 1'b0);
      send_frame(2, 2, ROT_180, 0, 0);
   endtask

   // corrupted sync word, then enough noise to run out the sync search
   task automatic test_sync_timeout();
      configure(MOD_BPSK, 8'hC3, 5'd2, 64'h9F3A_61D4_0B7E_52C8, 4'd8, 16'd64, 1'b0);
      send_frame(3, 3, ROT_NONE, 0, 20);
      send_noise(100);
      send_frame(2, 2, ROT_90, 1, 6);
   endtask

   task automatic test_clamped_registers();
      configure(MOD_BPSK, 8'h00, 5'd0, 64'hFFFF_FFFF_FFFF_FF6D, 4'd0, 16'd8, 1'b0);
      send_frame(2, 2, ROT_NONE, 0, 0);
      configure(MOD_QPSK, 8'hFF, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 16'd8, 1'b0);
      send_frame(1, 1, ROT_270, 3, 4);
      configure(MOD_BPSK, 8'h96, 5'd1, 64'h0000_0000_0000_0000, 4'd9, 16'd8, 1'b0);
      send_frame(2, 2, ROT_90, 0, 0);
   endtask

   task automatic test_receiver_stall();
      configure(MOD_BPSK, 8'hB4, 5'd2, 64'h1234_5678_9ABC_D2E7, 4'd2, 16'd1000, 1'b0);
      stall_start = 1'b1;
      send_frame(30, 30, ROT_NONE, 0, 0);
   endtask

   task automatic random_frame();
      int      kind, len, nbytes, pb, sb;
      rot_type r;
      pb = window_bytes();
      sb = sync_len_bytes();
      kind = $urandom_range(99);
      len  = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      if (cfg_mod == MOD_QPSK) r = rot_type'($urandom_range(3));
      else r = $urandom_range(1) ? ROT_90 : ROT_NONE;
      send_noise($urandom_range(12));
      if (kind < 70) begin
         send_frame(len, len, r, $urandom_range((pb * 4) / 10), $urandom_range(sb));
      end else if (kind < 78) begin
         send_noise($urandom_range(10, 40));
      end else if (kind < 86) begin
         nbytes = $urandom_range(len);
         send_frame($urandom_range(1) ? 0 : $urandom_range(65535), nbytes, r, 0, 0);
      end else if (kind < 93) begin
         send_frame(len, $urandom_range(len - 1), r, 0, 0);
      end else begin
         send_frame(len, len, r, $urandom_range(pb, pb * 2), $urandom_range(sb + 1, sb + 4));
      end
   endtask

   task automatic test_random_frames();
      int          round, pick;
      logic [7:0]  pbyte;
      logic [4:0]  pbytes;
      logic [3:0]  sbytes;
      logic [15:0] max_len;
      round = 0;
      while ((round == 0 || bits_sent < 1650) && round < 100) begin
         pick = $urandom_range(9);
         pbyte = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom());
         pick = $urandom_range(9);
         pbytes = (pick == 0) ? 5'd16 : (pick == 1) ? 5'($urandom_range(31)) :
                  (pick == 2) ? 5'($urandom_range(5, 15)) : 5'($urandom_range(2, 4));
         pick = $urandom_range(9);
         sbytes = (pick == 0) ? 4'd8 : (pick == 1) ? 4'($urandom_range(15)) :
                  (pick == 2) ? 4'($urandom_range(4, 7)) : 4'($urandom_range(1, 3));
         pick = $urandom_range(9);
         max_len = (pick == 0) ? 16'($urandom_range(4)) : (pick == 1) ? 16'hFFFF :
                   16'($urandom_range(8, 65535));
         configure(1'($urandom_range(1)), pbyte, pbytes, {$urandom(), $urandom()}, sbytes,
                   max_len, 1'($urandom_range(1)));
         steady = (round == 0);
         repeat ($urandom_range(3, 6)) random_frame();
         round++;
      end
      steady = 1'b0;
   endtask

   initial begin : rsp_side
      int         hold_left;
      result_type want;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_bytes.size() == 0) begin
               report_error($sformatf("unexpected word %02h last %0b phase %0d",
                  rsp_bus.payload_byte, rsp_bus.frame_last, rsp_bus.phase_found));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_bus.payload_byte !== want.payload_byte ||
                   rsp_bus.frame_last !== want.frame_last ||
                   rsp_bus.phase_found !== want.phase_found)
                  report_error($sformatf(
                     "word %0d: expected %02h last %0b phase %0d, got %02h last %0b phase %0d",
                     bytes_checked, want.payload_byte, want.frame_last, want.phase_found,
                     rsp_bus.payload_byte, rsp_bus.frame_last, rsp_bus.phase_found));
            end
            bytes_checked++;
         end
         if (stall_start) begin
            hold_left   = 400;
            stall_start = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(99) >= 24);
         end
      end
   end

   initial begin
      #3ms;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.rx_bit <= 1'b0;
      csr_bus.valid  <= 1'b0;
      csr_bus.index  <= CSR_MODULATION;
      csr_bus.data   <= '0;
      cfg_mod        = MOD_BPSK;
      cfg_pre_byte   = PREAMBLE_BYTE_RST;
      cfg_pre_bytes  = PREAMBLE_BYTES_RST;
      cfg_sync       = '0;
      cfg_sync_bytes = SYNC_BYTES_RST;
      cfg_max_len    = MAX_FRAME_RST;
      restart_search();
      rot_code = ROT_NONE;
      held_bit = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_bpsk_phases();
      test_qpsk_rotations();
      test_bad_lengths();
      test_sync_timeout();
      test_clamped_registers();
      test_receiver_stall();
      test_random_frames();

      req_bus.valid <= 1'b0;
      for (int k = 0; k < 5000 && expected_bytes.size() != 0; k++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (expected_bytes.size() != 0)
         report_error($sformatf("%0d expected words never arrived", expected_bytes.size()));
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/bfs_pkg.sv
rtl/bfs_if.sv
rtl/bfs_cell.sv
rtl/bfs_chain.sv
rtl/bfs_ctrl.sv
rtl/bfs_outq.sv
rtl/bit_frame_synchronizer.sv
tb/sv/bit_frame_synchronizer_tb.sv
